[design/mst_pkg.sv]
// Shared types, codes and constants of the multi-slot software timer.
`timescale 1ns / 1ps

package mst_pkg;

  // Default sizing
  localparam int unsigned NUM_SLOTS_DEF  = 32;
  localparam int unsigned TICK_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int unsigned ID_W   = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned NEXT_W = 31;
  localparam int unsigned FUNC_W = 2;

  // Saturation value of the reported next interval
  localparam logic [NEXT_W-1:0] NEXT_SAT = 31'h7fff_ffff;

  // Register reset values
  localparam logic [CFG_W-1:0] MIN_REG_RST  = 16'd4;
  localparam logic [CFG_W-1:0] MIN_TICK_RST = 16'd40;

  // Register indexes
  localparam logic REG_MIN_REGISTER = 1'b0;
  localparam logic REG_MIN_TICK     = 1'b1;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd2;

  // Result kinds
  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LOAD,
    ST_SCAN,
    ST_CLOSE
  } state_t;

  // Per-slot update outcome
  typedef struct packed {
    logic fired;  // count reached zero or below
    logic keep;   // slot stays active afterwards
  } slot_status_t;

endpackage

[design/mst_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module mst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/mst_slot_alu.sv]
// Per-slot countdown, expiry test and periodic reload arithmetic.
`timescale 1ns / 1ps

module mst_slot_alu #(
  parameter int unsigned TICK_WIDTH = mst_pkg::TICK_WIDTH_DEF
) (
  input  logic [TICK_WIDTH-1:0] remaining,
  input  logic [TICK_WIDTH-1:0] period,
  input  logic [TICK_WIDTH-1:0] elapsed,
  input  logic                  single,
  output mst_pkg::slot_status_t status,
  output logic [TICK_WIDTH-1:0] new_remaining
);

  logic                  fired;
  logic [TICK_WIDTH-1:0] diff;
  logic [TICK_WIDTH:0]   sum;
  logic [TICK_WIDTH:0]   reload_full;
  logic [TICK_WIDTH-1:0] reload;

  // Expired when the count would drop to zero or below
  assign fired = (remaining <= elapsed);
  assign diff  = remaining - elapsed;

  // Reload: remaining - elapsed + period, floored at zero (never above period)
  assign sum         = {1'b0, remaining} + {1'b0, period};
  assign reload_full = sum - {1'b0, elapsed};
  assign reload      = (sum > {1'b0, elapsed}) ? reload_full[TICK_WIDTH-1:0] : '0;

  always_comb begin
    if (!fired) begin
      new_remaining = diff;
    end else if (single) begin
      new_remaining = '0;
    end else begin
      new_remaining = reload;
    end
  end

  assign status.fired = fired;
  assign status.keep  = !fired || !single;

endmodule

[design/multi_slot_software_timer.sv]
// Top level of the multi-slot software timer table.
//
// Use: items enter on the in_ channel (in_valid / in_stall) and each gives a
// run of result beats on the out_ channel (out_valid / out_stall): one fire
// beat per expired slot in slot order, then one closing beat with out_last set.
// Two 16-bit minimum registers sit behind the APB port at byte addresses 0, 4.
// Slot state lives in one RAM entry per slot; valid bits are flip-flops.
// Work per item; a pass reads one slot per cycle through the RAM read port unless stalled:
//   tick                 countdown pass
//   register, id nonzero id search pass, slot load, countdown pass
//   unregister, id nonzero id search pass
//   anything else        closing beat only
// The rate is set by the single RAM read port visited once per slot per pass.
// Closing beats enter the output register from ST_CLOSE, fire beats from ST_SCAN.
// Reset frees every slot and restores the minimum registers; no clearing
// pass is needed. When the receiver stalls, the pass holds at the slot that
// must emit until the output register frees up; a new item is accepted once
// the closing beat is in the output register.
`timescale 1ns / 1ps

module multi_slot_software_timer #(
  parameter int unsigned NUM_SLOTS  = mst_pkg::NUM_SLOTS_DEF,
  parameter int unsigned TICK_WIDTH = mst_pkg::TICK_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_client_id,
  input  logic [31:0] in_interval_ticks,
  input  logic        in_one_shot,
  input  logic [31:0] in_elapsed_ticks,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [15:0] out_fired_id,
  output logic        out_ok,
  output logic        out_next_valid,
  output logic [30:0] out_next_interval,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW    = $clog2(NUM_SLOTS + 1);
  localparam int MW    = (TICK_WIDTH > 31) ? TICK_WIDTH : 31;
  localparam int ID_W  = mst_pkg::ID_W;
  localparam int ENT_W = 1 + 2 * TICK_WIDTH + ID_W;

  // RAM entry field positions
  localparam int REM_LO = ID_W;
  localparam int PER_LO = ID_W + TICK_WIDTH;
  localparam int SGL_B  = ENT_W - 1;

  // ---------------- state and registers ----------------
  mst_pkg::state_t state_r, state_nxt;

  logic [15:0]           cfg_min_reg_r;
  logic [15:0]           cfg_min_tick_r;

  logic [1:0]            func_r;
  logic [15:0]           id_r;
  logic [TICK_WIDTH-1:0] interval_r;
  logic                  single_r;
  logic [TICK_WIDTH-1:0] elapsed_r;

  logic [CW-1:0]         rd_idx_r;
  logic                  s1_v_r;
  logic [IW-1:0]         s1_idx_r;

  logic                  match_found_r;
  logic [IW-1:0]         match_idx_r;
  logic                  free_found_r;
  logic [IW-1:0]         free_idx_r;
  logic                  tgt_v_r;
  logic [IW-1:0]         tgt_idx_r;

  logic                  ok_r;
  logic                  any_r;
  logic [30:0]           min_r;

  logic [NUM_SLOTS-1:0]  slot_valid_r;

  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [15:0]           out_fired_id_r;
  logic                  out_ok_r;
  logic                  out_next_valid_r;
  logic [30:0]           out_next_interval_r;
  logic                  out_last_r;

  // ---------------- control signals ----------------
  logic                  in_accept;
  logic                  out_free;
  logic                  rd_more;
  logic                  pass_done;
  logic                  s1_live;
  logic                  skip_hit;
  logic                  need_emit;
  logic                  pipe_go;
  logic                  load_hit;
  logic [IW-1:0]         load_idx;
  logic                  out_load;
  logic                  cfg_wr;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [IW-1:0]         ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;

  logic [15:0]           ent_client;
  logic [TICK_WIDTH-1:0] ent_rem;
  logic [TICK_WIDTH-1:0] ent_per;
  logic                  ent_single;
  logic [TICK_WIDTH-1:0] elapsed_eff;

  mst_pkg::slot_status_t alu_status;
  logic [TICK_WIDTH-1:0] alu_rem;

  logic [15:0]           minimum;
  logic [30:0]           next_raised;

  // ---------------- slot store ----------------
  mst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent_client = ram_rdata[ID_W-1:0];
  assign ent_rem    = ram_rdata[REM_LO +: TICK_WIDTH];
  assign ent_per    = ram_rdata[PER_LO +: TICK_WIDTH];
  assign ent_single = ram_rdata[SGL_B];

  // Freshly loaded slot is not counted down in this item
  assign skip_hit    = tgt_v_r && (s1_idx_r == tgt_idx_r);
  assign elapsed_eff = skip_hit ? '0 : elapsed_r;

  mst_slot_alu #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_slot_alu (
    .remaining     (ent_rem),
    .period        (ent_per),
    .elapsed       (elapsed_eff),
    .single        (ent_single),
    .status        (alu_status),
    .new_remaining (alu_rem)
  );

  // ---------------- handshake and pass status ----------------
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_more   = (rd_idx_r != CW'(NUM_SLOTS));
  assign pass_done = !rd_more && !s1_v_r;
  assign s1_live   = s1_v_r && slot_valid_r[s1_idx_r];
  assign need_emit = s1_live && alu_status.fired;
  assign load_hit  = match_found_r || free_found_r;
  assign load_idx  = match_found_r ? match_idx_r : free_idx_r;
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign minimum     = (func_r == mst_pkg::FUNC_REGISTER) ? cfg_min_reg_r : cfg_min_tick_r;
  assign next_raised = (min_r < 31'(minimum)) ? 31'(minimum) : min_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mst_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_func)
            mst_pkg::FUNC_REGISTER,
            mst_pkg::FUNC_UNREGISTER: begin
              state_nxt = (in_client_id != '0) ? mst_pkg::ST_SEARCH : mst_pkg::ST_CLOSE;
            end
            mst_pkg::FUNC_TICK: begin
              state_nxt = mst_pkg::ST_SCAN;
            end
            default: begin
              state_nxt = mst_pkg::ST_CLOSE;
            end
          endcase
        end
      end
      mst_pkg::ST_SEARCH: begin
        if (pass_done) begin
          state_nxt = (func_r == mst_pkg::FUNC_REGISTER) ? mst_pkg::ST_LOAD : mst_pkg::ST_CLOSE;
        end
      end
      mst_pkg::ST_LOAD: begin
        state_nxt = mst_pkg::ST_SCAN;
      end
      mst_pkg::ST_SCAN: begin
        if (pass_done) begin
          state_nxt = mst_pkg::ST_CLOSE;
        end
      end
      mst_pkg::ST_CLOSE: begin
        if (out_free) begin
          state_nxt = mst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mst_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_stall  = 1'b1;
    pipe_go   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = s1_idx_r;
    ram_wdata = {ent_single, ent_per, alu_rem, ent_client};
    out_load  = 1'b0;
    case (state_r)
      mst_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      mst_pkg::ST_SEARCH: begin
        pipe_go = 1'b1;
      end
      mst_pkg::ST_LOAD: begin
        ram_we    = load_hit;
        ram_waddr = load_idx;
        ram_wdata = {single_r, interval_r, interval_r, id_r};
      end
      mst_pkg::ST_SCAN: begin
        // hold the pass while a fire beat cannot be placed
        pipe_go  = !need_emit || out_free;
        ram_we   = pipe_go && s1_live;
        out_load = pipe_go && need_emit;
      end
      mst_pkg::ST_CLOSE: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign ram_re    = pipe_go && rd_more;
  assign ram_raddr = rd_idx_r[IW-1:0];

  // ---------------- sequencer state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- item payload capture ----------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r     <= in_func;
      id_r       <= in_client_id;
      interval_r <= TICK_WIDTH'(in_interval_ticks);
      single_r   <= in_one_shot;
      elapsed_r  <= TICK_WIDTH'(in_elapsed_ticks);
    end
  end

  // ---------------- slot pass pipeline ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      s1_v_r   <= 1'b0;
    end else if (in_accept || (state_r == mst_pkg::ST_LOAD)) begin
      rd_idx_r <= '0;
      s1_v_r   <= 1'b0;
    end else if (pipe_go) begin
      if (rd_more) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        s1_v_r   <= 1'b1;
      end else begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_go && rd_more) begin
      s1_idx_r <= rd_idx_r[IW-1:0];
    end
  end

  // ---------------- id search results and load target ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      tgt_v_r       <= 1'b0;
    end else if (in_accept) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      tgt_v_r       <= 1'b0;
    end else if ((state_r == mst_pkg::ST_SEARCH) && s1_v_r) begin
      if (s1_live && (ent_client == id_r) && !match_found_r) begin
        match_found_r <= 1'b1;
      end
      if (!slot_valid_r[s1_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end else if (state_r == mst_pkg::ST_LOAD) begin
      tgt_v_r <= load_hit;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == mst_pkg::ST_SEARCH) && s1_v_r) begin
      if (s1_live && (ent_client == id_r) && !match_found_r) begin
        match_idx_r <= s1_idx_r;
      end
      if (!slot_valid_r[s1_idx_r] && !free_found_r) begin
        free_idx_r <= s1_idx_r;
      end
    end
    if (state_r == mst_pkg::ST_LOAD) begin
      tgt_idx_r <= load_idx;
    end
  end

  // ---------------- item status: ok flag, active flag, earliest count ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r  <= 1'b0;
      any_r <= 1'b0;
      min_r <= mst_pkg::NEXT_SAT;
    end else if (in_accept) begin
      ok_r  <= (in_func == mst_pkg::FUNC_TICK);
      any_r <= 1'b0;
      min_r <= mst_pkg::NEXT_SAT;
    end else begin
      if (state_r == mst_pkg::ST_LOAD) begin
        ok_r <= load_hit;
      end
      if ((state_r == mst_pkg::ST_SEARCH) && pass_done
          && (func_r == mst_pkg::FUNC_UNREGISTER)) begin
        ok_r <= match_found_r;
      end
      if ((state_r == mst_pkg::ST_SCAN) && pipe_go && s1_live && alu_status.keep) begin
        any_r <= 1'b1;
        if (MW'(alu_rem) < MW'(min_r)) begin
          min_r <= 31'(alu_rem);
        end
      end
    end
  end

  // ---------------- slot valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else begin
      if ((state_r == mst_pkg::ST_LOAD) && load_hit) begin
        slot_valid_r[load_idx] <= 1'b1;
      end
      if ((state_r == mst_pkg::ST_SCAN) && pipe_go && s1_live
          && alu_status.fired && !alu_status.keep) begin
        slot_valid_r[s1_idx_r] <= 1'b0;
      end
      if ((state_r == mst_pkg::ST_SEARCH) && pass_done
          && (func_r == mst_pkg::FUNC_UNREGISTER) && match_found_r) begin
        slot_valid_r[match_idx_r] <= 1'b0;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == mst_pkg::ST_CLOSE) begin
        out_kind_r          <= mst_pkg::KIND_CLOSE;
        out_fired_id_r      <= '0;
        out_ok_r            <= ok_r;
        out_next_valid_r    <= any_r;
        out_next_interval_r <= any_r ? next_raised : '0;
        out_last_r          <= 1'b1;
      end else begin
        out_kind_r          <= mst_pkg::KIND_FIRE;
        out_fired_id_r      <= ent_client;
        out_ok_r            <= 1'b0;
        out_next_valid_r    <= 1'b0;
        out_next_interval_r <= '0;
        out_last_r          <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_fired_id      = out_fired_id_r;
  assign out_ok            = out_ok_r;
  assign out_next_valid    = out_next_valid_r;
  assign out_next_interval = out_next_interval_r;
  assign out_last          = out_last_r;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_reg_r  <= mst_pkg::MIN_REG_RST;
      cfg_min_tick_r <= mst_pkg::MIN_TICK_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        mst_pkg::REG_MIN_REGISTER: cfg_min_reg_r  <= pwdata[15:0];
        mst_pkg::REG_MIN_TICK:     cfg_min_tick_r <= pwdata[15:0];
        default:                   cfg_min_reg_r  <= cfg_min_reg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mst_pkg::REG_MIN_REGISTER: prdata = {16'h0000, cfg_min_reg_r};
      mst_pkg::REG_MIN_TICK:     prdata = {16'h0000, cfg_min_tick_r};
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---------------- assertions ----------------
`ifndef SYNTHESIS
  // an accepted item always starts work
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != mst_pkg::ST_IDLE)
    else $error("accepted item left the sequencer idle");

  // write-back never hits the entry being read
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("slot RAM read and write collide");

  // stage index always trails the read counter
  a_s1_behind: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> CW'(s1_idx_r) < rd_idx_r)
    else $error("pass stage ahead of read counter");

  // a beat is only placed into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten");

  // fire beats carry no closing status
  a_fire_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == mst_pkg::KIND_FIRE) |-> !out_last_r && !out_next_valid_r)
    else $error("fire beat with closing fields");
`endif

endmodule
